// ===== hdl/wrdem_pkg.sv =====
// wrdem_pkg: shared types, constants and helper functions for the window rank/delay monitor
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package wrdem_pkg;

	localparam int WINDOW_DEF        = 256;
	localparam int RANK_BINS_DEF     = 64;
	localparam int DELAY_BINS_DEF    = 128;
	localparam int PRIORITY_BINS_DEF = 128;

	localparam int VT_W       = 48;
	localparam int TIME_W     = 48;
	localparam int WEIGHT_W   = 16;
	localparam int GROUP_W    = 8;
	localparam int IDX_W      = 9;
	localparam int CNT8_W     = 8;
	localparam int VAL_W      = 48;
	localparam int HIST_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WEIGHT_FILTER = 2'd0,
		CFG_PRIORITY_MODE = 2'd1,
		CFG_LOW_GROUP     = 2'd2,
		CFG_HIGH_GROUP    = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic signed [VT_W-1:0]     entry_vt;
		logic [TIME_W-1:0]          entry_time_in;
		logic [TIME_W-1:0]          entry_time_out;
		logic [WEIGHT_W-1:0]        entry_weight;
		logic [GROUP_W-1:0]         entry_group;
		logic [IDX_W-1:0]           stat_index;
	} item_t;

	typedef struct packed {
		logic                       evaluated;
		logic [CNT8_W-1:0]          rank_count;
		logic [CNT8_W-1:0]          delay_count;
		logic [CNT8_W-1:0]          priority_count;
		logic [VAL_W-1:0]           read_value;
	} result_t;

	typedef struct packed {
		logic signed [VT_W-1:0]     vt;
		logic [TIME_W-1:0]          time_in;
		logic [TIME_W-1:0]          time_out;
		logic [WEIGHT_W-1:0]        weight;
		logic [GROUP_W-1:0]         group;
	} win_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PUSH,
		S_CHECK,
		S_WALK,
		S_DRAIN,
		S_HRD,
		S_HWR,
		S_SRD,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		SEL_NONE,
		SEL_RANK,
		SEL_DELAY,
		SEL_PRIO,
		SEL_TOTAL,
		SEL_SUM_RANK,
		SEL_SUM_DELAY,
		SEL_SUM_PRIO,
		SEL_MAX_RANK,
		SEL_MAX_DELAY,
		SEL_MAX_PRIO
	} stat_sel_t;

	typedef struct packed {
		logic clr;
		logic load_in;
		logic push;
		logic chk;
		logic walk_start;
		logic walk_issue;
		logic hist_rd;
		logic hist_wr;
		logic stat_rd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic full_next;
		logic oldest_pass;
		logic newest_low;
		logic prio_mode;
		logic walk_last;
		logic op_read;
	} sts_t;

	function automatic logic [VAL_W-1:0] sat_add48(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[VAL_W] ? {VAL_W{1'b1}} : s[VAL_W-1:0];
	endfunction

	function automatic logic [HIST_W-1:0] sat_inc32(input logic [HIST_W-1:0] a);
		return (a == {HIST_W{1'b1}}) ? a : a + HIST_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/wrdem_ctrl.sv =====
// wrdem_ctrl: sequencing state machine of the monitor
// depends on wrdem_pkg; drives the datapath by cmd_t and reads sts_t
`timescale 1ns / 1ps
`default_nettype none

module wrdem_ctrl
	import wrdem_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_stall,
	output logic      result_valid,
	input  wire logic result_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   can_load;

	assign can_load     = !out_valid_q || !result_stall;
	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLEAR: if (sts.clr_done) state_nx = S_IDLE;
			S_IDLE: begin
				if (item_valid) state_nx = sts.op_read ? S_SRD : S_PUSH;
			end
			S_PUSH:  state_nx = sts.full_next ? S_CHECK : S_OUT;
			S_CHECK: begin
				if (!sts.oldest_pass) state_nx = S_OUT;
				else if (sts.prio_mode && sts.newest_low) state_nx = S_OUT;
				else state_nx = S_WALK;
			end
			S_WALK:  if (sts.walk_last) state_nx = S_DRAIN;
			S_DRAIN: state_nx = S_HRD;
			S_HRD:   state_nx = S_HWR;
			S_HWR:   state_nx = S_OUT;
			S_SRD:   state_nx = S_OUT;
			S_OUT:   if (can_load) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.clr        = (state_q == S_CLEAR);
		cmd.load_in    = (state_q == S_IDLE) && item_valid;
		cmd.push       = (state_q == S_PUSH);
		cmd.chk        = (state_q == S_CHECK);
		cmd.walk_start = (state_q == S_CHECK) && sts.oldest_pass &&
			!(sts.prio_mode && sts.newest_low);
		cmd.walk_issue = (state_q == S_WALK);
		cmd.hist_rd    = (state_q == S_HRD);
		cmd.hist_wr    = (state_q == S_HWR);
		cmd.stat_rd    = (state_q == S_SRD);
		cmd.load_out   = (state_q == S_OUT) && can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/wrdem_dp.sv =====
// wrdem_dp: window memory, walk counters, histogram memories, statistics and result register
// depends on wrdem_pkg; commanded by wrdem_ctrl
`timescale 1ns / 1ps
`default_nettype none

module wrdem_dp
	import wrdem_pkg::*;
#(
	parameter int WINDOW        = WINDOW_DEF,
	parameter int RANK_BINS     = RANK_BINS_DEF,
	parameter int DELAY_BINS    = DELAY_BINS_DEF,
	parameter int PRIORITY_BINS = PRIORITY_BINS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire item_t                 item,
	output result_t                    result,
	input  wire cmd_t                  cmd,
	output sts_t                       sts
);

	localparam int AW   = $clog2(WINDOW);
	localparam int FW   = $clog2(WINDOW + 1);
	localparam int CW   = AW;
	localparam int RAW  = $clog2(RANK_BINS > 1 ? RANK_BINS : 2);
	localparam int DAW  = $clog2(DELAY_BINS > 1 ? DELAY_BINS : 2);
	localparam int PAW  = $clog2(PRIORITY_BINS > 1 ? PRIORITY_BINS : 2);
	localparam int MAXB0 = RANK_BINS > DELAY_BINS ? RANK_BINS : DELAY_BINS;
	localparam int MAXB = MAXB0 > PRIORITY_BINS ? MAXB0 : PRIORITY_BINS;
	localparam int CLW  = $clog2(MAXB > 1 ? MAXB : 2);
	localparam int OFF_DELAY = RANK_BINS;
	localparam int OFF_PRIO  = RANK_BINS + DELAY_BINS;
	localparam int OFF_STAT  = RANK_BINS + DELAY_BINS + PRIORITY_BINS;
	localparam int SIW0 = $clog2(OFF_STAT + 8);
	localparam int SIW  = SIW0 > IDX_W ? SIW0 : IDX_W;

	function automatic logic [CNT8_W-1:0] clip8(input logic [CW-1:0] c);
		return (32'(c) > 255) ? {CNT8_W{1'b1}} : CNT8_W'(c);
	endfunction

	// configuration registers
	logic [WEIGHT_W-1:0] wf_q;
	logic                pm_q;
	logic [GROUP_W-1:0]  lg_q;
	logic [GROUP_W-1:0]  hg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wf_q <= '0;
			pm_q <= 1'b0;
			lg_q <= '0;
			hg_q <= GROUP_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_WEIGHT_FILTER: wf_q <= cfg_data[WEIGHT_W-1:0];
				CFG_PRIORITY_MODE: pm_q <= cfg_data[0];
				CFG_LOW_GROUP:     lg_q <= cfg_data[GROUP_W-1:0];
				CFG_HIGH_GROUP:    hg_q <= cfg_data[GROUP_W-1:0];
				default:           wf_q <= wf_q;
			endcase
		end
	end

	item_t it_q;
	always_ff @(posedge clk) begin
		if (cmd.load_in) it_q <= item;
	end

	// window pointers
	logic [FW-1:0] fill_q;
	logic [AW-1:0] oldest_q, newest_q, pos, oldest_nx;
	logic          full;

	assign full      = (fill_q == FW'(WINDOW));
	assign pos       = full ? oldest_q : fill_q[AW-1:0];
	assign oldest_nx = (pos == AW'(WINDOW - 1)) ? '0 : pos + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (cmd.push) begin
			if (full) oldest_q <= oldest_nx;
			else fill_q <= fill_q + FW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) newest_q <= pos;
	end

	// window memory
	win_t          win_mem [WINDOW];
	win_t          win_rd_q;
	win_t          win_wd;
	logic [AW-1:0] wptr_q, win_ra;

	assign win_wd = '{vt: it_q.entry_vt, time_in: it_q.entry_time_in,
		time_out: it_q.entry_time_out, weight: it_q.entry_weight,
		group: it_q.entry_group};
	assign win_ra = cmd.walk_issue ? wptr_q : oldest_nx;

	always_ff @(posedge clk) begin
		if (cmd.push) win_mem[pos] <= win_wd;
		win_rd_q <= win_mem[win_ra];
	end

	// walk
	logic [AW-1:0]          k_q, k_s1;
	logic                   v_s1, stop_q;
	logic [CW-1:0]          rank_q, dly_q, prio_q;
	logic [RAW-1:0]         rmod_q;
	logic signed [VT_W-1:0] old_vt_q;
	logic                   e_pass, rank_hit, dly_hit, prio_hit, e_high;

	assign e_pass   = (wf_q == '0) || (win_rd_q.weight == wf_q);
	assign rank_hit = v_s1 && !pm_q && (k_s1 != '0) && e_pass &&
		(win_rd_q.vt < old_vt_q);
	assign dly_hit  = v_s1 && !pm_q && (k_s1 != AW'(WINDOW - 1)) && e_pass &&
		(win_rd_q.vt > it_q.entry_vt);
	assign e_high   = (win_rd_q.group == hg_q);
	assign prio_hit = v_s1 && pm_q && !stop_q && !e_high &&
		(it_q.entry_time_in < win_rd_q.time_in) &&
		(it_q.entry_time_out > win_rd_q.time_out) &&
		(it_q.entry_vt < win_rd_q.vt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.walk_issue;
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		if (cmd.chk) old_vt_q <= win_rd_q.vt;
		if (cmd.walk_start) begin
			stop_q <= 1'b0;
			rank_q <= '0;
			dly_q  <= '0;
			prio_q <= '0;
			rmod_q <= '0;
			if (pm_q) begin
				wptr_q <= (newest_q == '0) ? AW'(WINDOW - 1) : newest_q - AW'(1);
				k_q    <= AW'(1);
			end else begin
				wptr_q <= oldest_q;
				k_q    <= '0;
			end
		end else begin
			if (cmd.walk_issue) begin
				k_q <= k_q + AW'(1);
				if (pm_q) wptr_q <= (wptr_q == '0) ? AW'(WINDOW - 1) : wptr_q - AW'(1);
				else wptr_q <= (wptr_q == AW'(WINDOW - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (rank_hit) begin
				rank_q <= rank_q + CW'(1);
				rmod_q <= (rmod_q == RAW'(RANK_BINS - 1)) ? '0 : rmod_q + RAW'(1);
			end
			if (dly_hit) dly_q <= dly_q + CW'(1);
			if (prio_hit) prio_q <= prio_q + CW'(1);
			if (v_s1 && pm_q && e_high) stop_q <= 1'b1;
		end
	end

	// statistic word decode
	logic [SIW-1:0] sidx, srel;
	stat_sel_t      ssel, ssel_q;
	logic [RAW-1:0] r_sa;
	logic [DAW-1:0] d_sa;
	logic [PAW-1:0] p_sa;

	assign sidx = SIW'(it_q.stat_index);
	assign srel = sidx - SIW'(OFF_STAT);
	assign r_sa = RAW'(sidx);
	assign d_sa = DAW'(sidx - SIW'(OFF_DELAY));
	assign p_sa = PAW'(sidx - SIW'(OFF_PRIO));

	always_comb begin
		ssel = SEL_NONE;
		if (sidx < SIW'(RANK_BINS)) ssel = SEL_RANK;
		else if (sidx < SIW'(OFF_PRIO)) ssel = SEL_DELAY;
		else if (sidx < SIW'(OFF_STAT)) ssel = SEL_PRIO;
		else begin
			case (srel)
				SIW'(0): ssel = SEL_TOTAL;
				SIW'(1): ssel = SEL_SUM_RANK;
				SIW'(2): ssel = SEL_SUM_DELAY;
				SIW'(3): ssel = SEL_SUM_PRIO;
				SIW'(4): ssel = SEL_MAX_RANK;
				SIW'(5): ssel = SEL_MAX_DELAY;
				SIW'(6): ssel = SEL_MAX_PRIO;
				default: ssel = SEL_NONE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.stat_rd) ssel_q <= ssel;
	end

	// histogram memories with clearing pass
	logic [CLW-1:0]    clr_q;
	logic [HIST_W-1:0] rank_mem [RANK_BINS];
	logic [HIST_W-1:0] dly_mem  [DELAY_BINS];
	logic [HIST_W-1:0] prio_mem [PRIORITY_BINS];
	logic [HIST_W-1:0] rank_rd_q, dly_rd_q, prio_rd_q;
	logic [RAW-1:0]    rank_ra, rank_wa;
	logic [DAW-1:0]    dly_ra, dly_wa;
	logic [PAW-1:0]    prio_ra, prio_wa;
	logic              rank_we, dly_we, prio_we, hist_re, dly_in, prio_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr) clr_q <= clr_q + CLW'(1);
	end

	assign dly_in  = (32'(dly_q) < DELAY_BINS);
	assign prio_in = (32'(prio_q) < PRIORITY_BINS);
	assign hist_re = cmd.hist_rd || cmd.stat_rd;
	assign rank_ra = cmd.stat_rd ? r_sa : rmod_q;
	assign dly_ra  = cmd.stat_rd ? d_sa : DAW'(dly_q);
	assign prio_ra = cmd.stat_rd ? p_sa : PAW'(prio_q);
	assign rank_wa = cmd.clr ? RAW'(clr_q) : rmod_q;
	assign dly_wa  = cmd.clr ? DAW'(clr_q) : DAW'(dly_q);
	assign prio_wa = cmd.clr ? PAW'(clr_q) : PAW'(prio_q);
	assign rank_we = cmd.clr ? (32'(clr_q) < RANK_BINS) : (cmd.hist_wr && !pm_q);
	assign dly_we  = cmd.clr ? (32'(clr_q) < DELAY_BINS) :
		(cmd.hist_wr && !pm_q && dly_in);
	assign prio_we = cmd.clr ? (32'(clr_q) < PRIORITY_BINS) :
		(cmd.hist_wr && pm_q && prio_in);

	always_ff @(posedge clk) begin
		if (rank_we) rank_mem[rank_wa] <= cmd.clr ? '0 : sat_inc32(rank_rd_q);
		if (hist_re) rank_rd_q <= rank_mem[rank_ra];
	end

	always_ff @(posedge clk) begin
		if (dly_we) dly_mem[dly_wa] <= cmd.clr ? '0 : sat_inc32(dly_rd_q);
		if (hist_re) dly_rd_q <= dly_mem[dly_ra];
	end

	always_ff @(posedge clk) begin
		if (prio_we) prio_mem[prio_wa] <= cmd.clr ? '0 : sat_inc32(prio_rd_q);
		if (hist_re) prio_rd_q <= prio_mem[prio_ra];
	end

	// running statistics
	logic [VAL_W-1:0]  total_q;
	logic [VAL_W-1:0]  sum_q [3];
	logic [CNT8_W-1:0] max_q [3];
	logic              eval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			sum_q   <= '{default: '0};
			max_q   <= '{default: '0};
			eval_q  <= 1'b0;
		end else begin
			if (cmd.load_in) eval_q <= 1'b0;
			if (cmd.chk && sts.oldest_pass) total_q <= sat_add48(total_q, VAL_W'(1));
			if (cmd.hist_wr) begin
				eval_q <= 1'b1;
				if (pm_q) begin
					sum_q[2] <= sat_add48(sum_q[2], VAL_W'(prio_q));
					if (clip8(prio_q) > max_q[2]) max_q[2] <= clip8(prio_q);
				end else begin
					sum_q[0] <= sat_add48(sum_q[0], VAL_W'(rank_q));
					sum_q[1] <= sat_add48(sum_q[1], VAL_W'(dly_q));
					if (clip8(rank_q) > max_q[0]) max_q[0] <= clip8(rank_q);
					if (clip8(dly_q) > max_q[1]) max_q[1] <= clip8(dly_q);
				end
			end
		end
	end

	// result register
	logic [VAL_W-1:0] stat_val;
	result_t          res_nx, res_q;

	always_comb begin
		case (ssel_q)
			SEL_RANK:      stat_val = VAL_W'(rank_rd_q);
			SEL_DELAY:     stat_val = VAL_W'(dly_rd_q);
			SEL_PRIO:      stat_val = VAL_W'(prio_rd_q);
			SEL_TOTAL:     stat_val = total_q;
			SEL_SUM_RANK:  stat_val = sum_q[0];
			SEL_SUM_DELAY: stat_val = sum_q[1];
			SEL_SUM_PRIO:  stat_val = sum_q[2];
			SEL_MAX_RANK:  stat_val = VAL_W'(max_q[0]);
			SEL_MAX_DELAY: stat_val = VAL_W'(max_q[1]);
			SEL_MAX_PRIO:  stat_val = VAL_W'(max_q[2]);
			default:       stat_val = '0;
		endcase
	end

	always_comb begin
		res_nx = '0;
		if (it_q.op == OP_READ) begin
			res_nx.read_value = stat_val;
		end else if (eval_q) begin
			res_nx.evaluated = 1'b1;
			if (pm_q) begin
				res_nx.priority_count = clip8(prio_q);
			end else begin
				res_nx.rank_count  = clip8(rank_q);
				res_nx.delay_count = clip8(dly_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) res_q <= res_nx;
	end

	assign result = res_q;

	assign sts.clr_done    = (clr_q == CLW'(MAXB - 1));
	assign sts.full_next   = full || (fill_q == FW'(WINDOW - 1));
	assign sts.oldest_pass = e_pass;
	assign sts.newest_low  = (it_q.entry_group == lg_q);
	assign sts.prio_mode   = pm_q;
	assign sts.walk_last   = (k_q == AW'(WINDOW - 1));
	assign sts.op_read     = (item.op == OP_READ);

endmodule

`default_nettype wire

// ===== hdl/window_rank_delay_error_monitor.sv =====
// window_rank_delay_error_monitor: top level of the sliding-window error monitor
// depends on wrdem_pkg, wrdem_ctrl and wrdem_dp
//
// channel   direction  handshake                   payload
// item      in         item_valid / item_stall     item (item_t)
// result    out        result_valid / result_stall result (result_t)
// cfg       in         cfg_we                      cfg_index, cfg_data
//
// a read request, a push on a partly filled window and a push whose oldest entry
// fails the weight filter finish without a walk
// an evaluated push walks the window: the walk reads the window
// memory once per entry through its single read port
// after reset a clearing pass over max(RANK_BINS, DELAY_BINS, PRIORITY_BINS)
// bins zeroes the histograms; item_stall stays high meanwhile
// a new request is taken while the previous result waits on result_stall
`timescale 1ns / 1ps
`default_nettype none

module window_rank_delay_error_monitor
	import wrdem_pkg::*;
#(
	parameter int WINDOW        = WINDOW_DEF,
	parameter int RANK_BINS     = RANK_BINS_DEF,
	parameter int DELAY_BINS    = DELAY_BINS_DEF,
	parameter int PRIORITY_BINS = PRIORITY_BINS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request channel
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire item_t                 item,
	// result channel
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	// configuration writes, only while idle
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// commands from the sequencer, status back from the datapath
	cmd_t cmd;
	sts_t sts;

	// state machine: clearing pass, push, oldest check, walk, histogram update, statistic read, result output
	wrdem_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// window memory, error counters, histograms and statistic registers
	wrdem_dp #(
		.WINDOW        (WINDOW),
		.RANK_BINS     (RANK_BINS),
		.DELAY_BINS    (DELAY_BINS),
		.PRIORITY_BINS (PRIORITY_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.result    (result),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// ===== hdl/wrdem_chk.sv =====
// wrdem_chk: port-level checker for the monitor, attached by bind
// depends on wrdem_pkg and window_rank_delay_error_monitor
`timescale 1ns / 1ps
`default_nettype none

module wrdem_chk
	import wrdem_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("request taken while busy");

	// normal and priority counts never appear together
	a_modes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.priority_count != '0 |->
			result.rank_count == '0 && result.delay_count == '0)
		else $error("mixed mode counts");

	// counts only come with the evaluated flag, and never with read data
	a_eval: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.evaluated |->
			result.rank_count == '0 && result.delay_count == '0 &&
			result.priority_count == '0)
		else $error("counts without evaluation");

	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.evaluated |-> result.read_value == '0)
		else $error("read value on a push result");

endmodule

bind window_rank_delay_error_monitor wrdem_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking bench for window_rank_delay_error_monitor
// depends on wrdem_pkg and the rtl of the block; a small scoreboard class predicts results
`timescale 1ns / 1ps

module tb;
	import wrdem_pkg::*;

	localparam int WIN       = 256;
	localparam int R_BINS    = 64;
	localparam int D_BINS    = 128;
	localparam int P_BINS    = 128;
	localparam int STAT_BASE = R_BINS + D_BINS + P_BINS;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	// predicts each result of the monitor and checks what comes back
	class window_stats_scoreboard;
		logic [15:0] weight_filter;
		logic        priority_mode;
		logic [7:0]  low_group;
		logic [7:0]  high_group;

		logic signed [47:0] w_vt[WIN];
		logic [47:0] w_tin[WIN];
		logic [47:0] w_tout[WIN];
		logic [15:0] w_weight[WIN];
		logic [7:0]  w_group[WIN];
		logic [7:0]  oldest;
		int          fill;
		logic [31:0] rank_hist[R_BINS];
		logic [31:0] delay_hist[D_BINS];
		logic [31:0] prio_hist[P_BINS];
		logic [47:0] eval_total;
		logic [47:0] sums[3];
		logic [7:0]  maxima[3];

		result_t expected_q[$];
		int errors;
		int n_push, n_read, n_eval;

		function new();
			weight_filter = 0;
			priority_mode = 0;
			low_group = 0;
			high_group = 1;
			oldest = 0;
			fill = 0;
			foreach (rank_hist[i]) rank_hist[i] = 0;
			foreach (delay_hist[i]) delay_hist[i] = 0;
			foreach (prio_hist[i]) prio_hist[i] = 0;
			eval_total = 0;
			foreach (sums[i]) begin
				sums[i] = 0;
				maxima[i] = 0;
			end
			errors = 0;
			n_push = 0;
			n_read = 0;
			n_eval = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [15:0] data);
			case (idx)
				CFG_WEIGHT_FILTER: weight_filter = data;
				CFG_PRIORITY_MODE: priority_mode = data[0];
				CFG_LOW_GROUP: low_group = data[7:0];
				CFG_HIGH_GROUP: high_group = data[7:0];
			endcase
		endfunction

		function logic [47:0] add_sat(logic [47:0] a, int unsigned b);
			logic [48:0] s;
			s = {1'b0, a} + 49'(b);
			return s[48] ? MAX48 : s[47:0];
		endfunction

		function logic [7:0] clip(int unsigned c);
			return (c > 255) ? 8'd255 : c[7:0];
		endfunction

		function void bump(ref logic [31:0] bin);
			if (bin != 32'hFFFF_FFFF) bin = bin + 1;
		endfunction

		function void accumulate(int which, int unsigned c);
			sums[which] = add_sat(sums[which], c);
			if (clip(c) > maxima[which]) maxima[which] = clip(c);
		endfunction

		function bit counts(int p);
			return weight_filter == 0 || w_weight[p] == weight_filter;
		endfunction

		function logic [47:0] stat_word(int unsigned idx);
			if (idx < R_BINS) return rank_hist[idx];
			if (idx < R_BINS + D_BINS) return delay_hist[idx - R_BINS];
			if (idx < STAT_BASE) return prio_hist[idx - R_BINS - D_BINS];
			if (idx == STAT_BASE) return eval_total;
			if (idx <= STAT_BASE + 3) return sums[idx - STAT_BASE - 1];
			if (idx <= STAT_BASE + 6) return maxima[idx - STAT_BASE - 4];
			return 0;
		endfunction

		// accepted request: work out its result and queue it
		function void note_request(item_t it);
			result_t r;
			int pos, old_p, new_p;
			int unsigned rank, dly, prio;
			r = '0;
			rank = 0;
			dly = 0;
			prio = 0;
			if (it.op == OP_READ) begin
				n_read++;
				r.read_value = stat_word(it.stat_index);
				expected_q.push_back(r);
				return;
			end
			n_push++;
			if (fill < WIN) begin
				pos = fill;
				fill++;
			end else begin
				pos = oldest;
				oldest = oldest + 1;
			end
			w_vt[pos] = it.entry_vt;
			w_tin[pos] = it.entry_time_in;
			w_tout[pos] = it.entry_time_out;
			w_weight[pos] = it.entry_weight;
			w_group[pos] = it.entry_group;
			old_p = oldest;
			new_p = (old_p + WIN - 1) % WIN;
			if (fill < WIN || !counts(old_p)) begin
				expected_q.push_back(r);
				return;
			end
			eval_total = add_sat(eval_total, 1);
			if (!priority_mode) begin
				for (int k = 1; k < WIN; k++) begin
					pos = (old_p + k) % WIN;
					if (counts(pos) && w_vt[pos] < w_vt[old_p]) rank++;
					pos = (new_p + WIN - k) % WIN;
					if (counts(pos) && w_vt[pos] > w_vt[new_p]) dly++;
				end
				accumulate(0, rank);
				bump(rank_hist[rank % R_BINS]);
				accumulate(1, dly);
				if (dly < D_BINS) bump(delay_hist[dly]);
				r.evaluated = 1'b1;
				r.rank_count = clip(rank);
				r.delay_count = clip(dly);
				n_eval++;
			end else if (w_group[new_p] != low_group) begin
				for (int k = 1; k < WIN; k++) begin
					pos = (new_p + WIN - k) % WIN;
					if (w_group[pos] == high_group) break;
					if (w_tin[new_p] < w_tin[pos] && w_tout[new_p] > w_tout[pos]
							&& w_vt[new_p] < w_vt[pos])
						prio++;
				end
				accumulate(2, prio);
				if (prio < P_BINS) bump(prio_hist[prio]);
				r.evaluated = 1'b1;
				r.priority_count = clip(prio);
				n_eval++;
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: %p", got);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.evaluated !== exp_r.evaluated) begin
				$error("evaluated: expected %0d, got %0d", exp_r.evaluated, got.evaluated);
				errors++;
			end
			if (got.rank_count !== exp_r.rank_count) begin
				$error("rank_count: expected %0d, got %0d", exp_r.rank_count, got.rank_count);
				errors++;
			end
			if (got.delay_count !== exp_r.delay_count) begin
				$error("delay_count: expected %0d, got %0d",
					exp_r.delay_count, got.delay_count);
				errors++;
			end
			if (got.priority_count !== exp_r.priority_count) begin
				$error("priority_count: expected %0d, got %0d",
					exp_r.priority_count, got.priority_count);
				errors++;
			end
			if (got.read_value !== exp_r.read_value) begin
				$error("read_value: expected %0h, got %0h",
					exp_r.read_value, got.read_value);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	window_rank_delay_error_monitor dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	window_stats_scoreboard sb = new();

	int cycles = 0;
	int burst_left = 0;
	int results_seen = 0;
	bit hold_done = 0;
	int hold_left = 0;
	int stall_mode = 0;
	logic signed [47:0] ramp_vt = 48'sd1000;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// cycle counter and timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// result side: check on accepted results at the rising edge
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(result);
			results_seen <= results_seen + 1;
		end
	end

	// result side: stall pattern picked at random from four modes, plus one long hold-off
	always @(negedge clk) begin
		if (cycles % 200 == 0) stall_mode = $urandom_range(0, 3);
		if (!hold_done && results_seen >= 40) begin
			hold_done = 1;
			hold_left = 2000;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall = 1'b1;
		end else begin
			case (stall_mode)
				0: result_stall = 1'b0;
				1: result_stall = ($urandom_range(0, 3) == 0);
				2: result_stall = ($urandom_range(0, 9) < 7);
				default: result_stall = (cycles % 3 == 0);
			endcase
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// random request: mostly pushes from small value sets so the windows interact
	function automatic item_t make_item();
		item_t it;
		int sel;
		it = '0;
		it.op = ($urandom_range(0, 4) == 0) ? OP_READ : OP_PUSH;
		it.stat_index = 9'($urandom_range(0, 511));
		sel = $urandom_range(0, 19);
		if (sel < 10) begin
			it.entry_vt = $signed(48'($urandom_range(0, 40))) - 48'sd20;
		end else if (sel < 14) begin
			// falling run drives delay counts high
			ramp_vt = ramp_vt - 1;
			it.entry_vt = ramp_vt;
		end else if (sel < 17) begin
			it.entry_vt = rand48();
		end else begin
			it.entry_vt = sel[0] ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
		end
		if ($urandom_range(0, 3) != 0) begin
			it.entry_time_in = 48'($urandom_range(0, 30));
			it.entry_time_out = 48'($urandom_range(0, 30));
		end else begin
			it.entry_time_in = rand48();
			it.entry_time_out = rand48();
		end
		case ($urandom_range(0, 5))
			0, 1: it.entry_weight = 16'd2;
			2: it.entry_weight = 16'hFFFF;
			3: it.entry_weight = 16'd1;
			4: it.entry_weight = 16'd0;
			default: it.entry_weight = 16'($urandom());
		endcase
		case ($urandom_range(0, 9))
			0: it.entry_group = 8'hFF;
			1: it.entry_group = 8'($urandom());
			default: it.entry_group = 8'($urandom_range(0, 3));
		endcase
		return it;
	endfunction

	// offer one request, hold it until taken, then maybe leave a gap
	task automatic send(item_t it);
		item_valid = 1'b1;
		item = it;
		forever begin
			@(posedge clk);
			if (!item_stall) break;
		end
		sb.note_request(it);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			item_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
		end
	endtask

	// wait until every expected result is back, plus a short settle
	task automatic drain();
		item_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic configure(logic [15:0] wf, logic pm, logic [7:0] lo, logic [7:0] hi);
		drain();
		write_reg(CFG_WEIGHT_FILTER, wf);
		write_reg(CFG_PRIORITY_MODE, {15'd0, pm});
		write_reg(CFG_LOW_GROUP, {8'd0, lo});
		write_reg(CFG_HIGH_GROUP, {8'd0, hi});
	endtask

	task automatic send_random(int n);
		repeat (n) send(make_item());
	endtask

	task automatic send_read(int idx);
		item_t it;
		it = '0;
		it.op = OP_READ;
		it.stat_index = 9'(idx);
		send(it);
	endtask

	task automatic send_push(logic signed [47:0] vt, logic [47:0] tin, logic [47:0] tout,
			logic [15:0] wt, logic [7:0] grp);
		item_t it;
		it = '0;
		it.op = OP_PUSH;
		it.entry_vt = vt;
		it.entry_time_in = tin;
		it.entry_time_out = tout;
		it.entry_weight = wt;
		it.entry_group = grp;
		send(it);
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WEIGHT_FILTER;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: statistic boundaries, out-of-range indices, field extremes
		send_read(0);
		send_read(R_BINS - 1);
		send_read(R_BINS);
		send_read(STAT_BASE - 1);
		for (int i = 0; i <= 7; i++) send_read(STAT_BASE + i);
		send_read(511);
		send_push(48'sh7FFF_FFFF_FFFF, 48'd0, MAX48, 16'hFFFF, 8'hFF);
		send_push(48'sh8000_0000_0000, MAX48, 48'd0, 16'd0, 8'd0);
		send_push(48'sd0, 48'd0, 48'd0, 16'd1, 8'd1);
		send_push(-48'sd1, MAX48, MAX48, 16'd2, 8'd2);
		send_push(48'sd1, 48'd5, 48'd10, 16'd2, 8'd3);

		// random traffic under default settings, then under five further settings
		send_random(300);
		configure(16'd2, 1'b0, 8'd0, 8'd1);
		send_random(200);
		configure(16'd0, 1'b1, 8'd0, 8'd1);
		send_random(200);
		configure(16'hFFFF, 1'b1, 8'hFF, 8'hFF);
		send_random(150);
		configure(16'd0, 1'b1, 8'd3, 8'hFF);
		send_random(150);
		configure(16'd0, 1'b0, 8'd3, 8'd0);
		send_random(250);
		for (int i = 0; i <= 7; i++) send_read(STAT_BASE + i);

		drain();
		repeat (300) @(negedge clk);
		$display("covered %0d pushes (%0d evaluated) and %0d reads over six settings",
			sb.n_push, sb.n_eval, sb.n_read);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ===== window_rank_delay_error_monitor.f =====
hdl/wrdem_pkg.sv
hdl/wrdem_ctrl.sv
hdl/wrdem_dp.sv
hdl/window_rank_delay_error_monitor.sv
hdl/wrdem_chk.sv
dv/tb.sv
